@@ rtl/cknl_pkg.sv @@
// Package for the command line key lookup block: codes, widths and the
// character tables used by the byte scanner. No dependencies.
`default_nettype none

package cknl_pkg;

  localparam int DATA_W          = 64;
  localparam int KEY_LEN_W       = 5;
  localparam int CFG_INDEX_W     = 2;
  localparam int MAX_KEY_BYTES_D = 16;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 64;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT  = 2'd3;

  // Scan phase
  localparam logic [1:0] PH_MATCH = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // Number stage
  localparam logic [1:0] NS_FIRST  = 2'd0;
  localparam logic [1:0] NS_ZERO   = 2'd1;
  localparam logic [1:0] NS_DIGITS = 2'd2;
  localparam logic [1:0] NS_STOP   = 2'd3;

  // Radix select
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_HEX = 2'd1;
  localparam logic [1:0] RX_BIN = 2'd2;
  localparam logic [1:0] RX_OCT = 2'd3;

  // Affirmative words
  localparam logic [1:0] WORD_TRUE = 2'd0;
  localparam logic [1:0] WORD_YES  = 2'd1;
  localparam logic [1:0] WORD_YEAH = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_EQ    = 8'h3d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X_LC  = 8'h78;
  localparam logic [7:0] CHAR_X_UC  = 8'h58;
  localparam logic [7:0] CHAR_B_LC  = 8'h62;
  localparam logic [7:0] CHAR_B_UC  = 8'h42;

  // {ok, digit value}
  function automatic logic [4:0] digit_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h61 + 8'd10)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h41 + 8'd10)};
    return r;
  endfunction

  function automatic logic [4:0] radix_limit(input logic [1:0] sel);
    logic [4:0] r;
    case (sel)
      RX_DEC:  r = 5'd10;
      RX_HEX:  r = 5'd16;
      RX_BIN:  r = 5'd2;
      RX_OCT:  r = 5'd8;
      default: r = 5'd10;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] word_len(input logic [1:0] w);
    logic [2:0] r;
    case (w)
      WORD_TRUE: r = 3'd4;
      WORD_YES:  r = 3'd3;
      WORD_YEAH: r = 3'd4;
      default:   r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] word_char(input logic [1:0] w, input logic [1:0] i);
    logic [31:0] s;
    case (w)
      WORD_TRUE: s = {8'h65, 8'h75, 8'h72, 8'h74};  // "true", first char low
      WORD_YES:  s = {8'h00, 8'h73, 8'h65, 8'h79};  // "yes"
      WORD_YEAH: s = {8'h68, 8'h61, 8'h65, 8'h79};  // "yeah"
      default:   s = 32'd0;
    endcase
    return s[{i, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

@@ rtl/cmdline_key_number_lookup.sv @@
// Command line key lookup: byte scanner, number parser and result buffer.
// Depends on cknl_pkg.
`default_nettype none

// Usage
//   Input stream (s_*): one command line character per request in s_tdata,
//   s_tlast high on the final character of a line. Output stream (m_*): one
//   result request per line, result_value in m_tdata and found in m_tuser.
//   Configuration: cfg_we / cfg_index / cfg_data write the key (low and
//   high eight characters), the key length and the default value. Write
//   only while no line is in flight.
// Throughput and datapath
//   One character per cycle while s_tready is high. Each accepted
//   character updates the scan state in the cycle it is accepted; the path
//   is one key byte compare, the digit decode and a shift-and-add of the
//   64-bit accumulator by the radix. The result of a line is registered
//   into the output register, or the skid register while that one is full.
// Stall behavior
//   An output register plus one skid register hold results, so input keeps
//   flowing while a result waits. s_tready drops only when both are full.
// Reset
//   rst (synchronous, active high) clears configuration to zero, returns
//   the scanner to the start of a line and empties the result buffer.
module cmdline_key_number_lookup #(
  parameter int MAX_KEY_BYTES = cknl_pkg::MAX_KEY_BYTES_D
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [cknl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [cknl_pkg::DATA_W-1:0]           cfg_data,
  // Character stream
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [cknl_pkg::IN_TDATA_W-1:0]       s_tdata,   // [7:0] text_byte
  input  wire logic                                  s_tlast,   // last_byte
  // Result stream
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [cknl_pkg::OUT_TDATA_W-1:0]           m_tdata,   // [63:0] result_value
  output logic                                       m_tuser    // [0] found
);

  import cknl_pkg::*;

  localparam int KEY_W = MAX_KEY_BYTES * 8;
  localparam int KP_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam int KI_W  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  // Configuration registers
  logic [KEY_W-1:0]     key_text;
  logic [KEY_LEN_W-1:0] key_length;
  logic [DATA_W-1:0]    default_value;

  // Scan state
  logic [KP_W-1:0]   key_position, key_position_next;
  logic [1:0]        scan_phase, scan_phase_next;
  logic [1:0]        number_stage, number_stage_next;
  logic [1:0]        radix_select, radix_select_next;
  logic [DATA_W-1:0] accumulator, accumulator_next;
  logic [2:0]        word_alive, word_alive_next;
  logic [2:0]        value_count, value_count_next;

  // Result buffer
  logic                   out_valid, skid_valid;
  logic [DATA_W:0]        out_data, skid_data;   // {result_value, found}

  logic [7:0]        b;
  logic              accept, push, pop;
  logic [KP_W-1:0]   klen;
  logic [7:0]        key_char;
  logic [1:0]        eff_radix;
  logic [4:0]        digit;
  logic              digit_ok;
  logic [DATA_W-1:0] acc_shifted, acc_fed;
  logic [2:0]        word_hit;
  logic              found, word;
  logic [DATA_W-1:0] result_value;

  assign b      = s_tdata[7:0];
  assign accept = s_tvalid && s_tready;
  assign push   = accept && s_tlast;
  assign pop    = out_valid && m_tready;

  // Key lengths beyond the storage act as the full storage
  assign klen = (key_length > KEY_LEN_W'(MAX_KEY_BYTES)) ? KP_W'(MAX_KEY_BYTES)
                                                          : key_length[KP_W-1:0];
  assign key_char = key_text[{key_position[KI_W-1:0], 3'b000} +: 8];

  // The first value character decides decimal; after a lone zero a
  // non-prefix character is read as an octal digit, else the number ends.
  always_comb begin
    case (number_stage)
      NS_FIRST: eff_radix = RX_DEC;
      NS_ZERO:  eff_radix = RX_OCT;
      default:  eff_radix = radix_select;
    endcase
  end

  assign digit    = digit_decode(b);
  assign digit_ok = digit[4] && ({1'b0, digit[3:0]} < radix_limit(eff_radix));

  // Multiply by the radix as shifts and adds
  always_comb begin
    case (eff_radix)
      RX_DEC:  acc_shifted = (accumulator << 3) + (accumulator << 1);
      RX_HEX:  acc_shifted = accumulator << 4;
      RX_BIN:  acc_shifted = accumulator << 1;
      RX_OCT:  acc_shifted = accumulator << 3;
      default: acc_shifted = accumulator;
    endcase
  end
  assign acc_fed = acc_shifted + DATA_W'(digit[3:0]);

  always_comb begin
    for (int w = 0; w < 3; w++) begin
      word_hit[w] = (value_count < word_len(2'(w))) &&
                    (b == word_char(2'(w), value_count[1:0]));
    end
  end

  // Next scan state for the character on s_tdata
  always_comb begin
    key_position_next = key_position;
    scan_phase_next   = scan_phase;
    number_stage_next = number_stage;
    radix_select_next = radix_select;
    accumulator_next  = accumulator;
    word_alive_next   = word_alive;
    value_count_next  = value_count;
    case (scan_phase)
      PH_MATCH: begin
        if (klen == '0) begin
          scan_phase_next = (b == CHAR_SPACE) ? PH_MATCH : PH_SKIP;
        end else if (key_position < klen && b == key_char) begin
          key_position_next = key_position + 1'b1;
        end else if (key_position == klen && b == CHAR_EQ) begin
          scan_phase_next = PH_VALUE;
        end else begin
          key_position_next = '0;
          if (b != CHAR_SPACE) scan_phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == CHAR_SPACE) begin
          scan_phase_next   = PH_MATCH;
          key_position_next = '0;
        end
      end
      PH_VALUE: begin
        if (b == CHAR_SPACE) begin
          scan_phase_next = PH_DONE;
        end else begin
          word_alive_next = word_alive & word_hit;
          if (value_count != 3'd7) value_count_next = value_count + 1'b1;
          case (number_stage)
            NS_FIRST: begin
              if (b == CHAR_ZERO) begin
                number_stage_next = NS_ZERO;
              end else begin
                radix_select_next = RX_DEC;
                if (digit_ok) begin
                  number_stage_next = NS_DIGITS;
                  accumulator_next  = acc_fed;
                end else begin
                  number_stage_next = NS_STOP;
                end
              end
            end
            NS_ZERO: begin
              number_stage_next = NS_DIGITS;
              if (b == CHAR_X_LC || b == CHAR_X_UC) begin
                radix_select_next = RX_HEX;
              end else if (b == CHAR_B_LC || b == CHAR_B_UC) begin
                radix_select_next = RX_BIN;
              end else begin
                radix_select_next = RX_OCT;
                if (digit_ok) accumulator_next = acc_fed;
                else number_stage_next = NS_STOP;
              end
            end
            NS_DIGITS: begin
              if (digit_ok) accumulator_next = acc_fed;
              else number_stage_next = NS_STOP;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Line result from the state after the last character
  always_comb begin
    found = (klen != '0) && (scan_phase_next == PH_VALUE || scan_phase_next == PH_DONE)
            && (value_count_next != 3'd0);
    word  = (word_alive_next[0] && value_count_next == word_len(WORD_TRUE)) ||
            (word_alive_next[1] && value_count_next == word_len(WORD_YES))  ||
            (word_alive_next[2] && value_count_next == word_len(WORD_YEAH));
    if (!found) result_value = default_value;
    else if (default_value[DATA_W-1:1] == '0 && word) result_value = DATA_W'(1);
    else result_value = accumulator_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_text      <= '0;
      key_length    <= '0;
      default_value <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        if ((i < 8 && cfg_index == REG_KEY_LOW) || (i >= 8 && cfg_index == REG_KEY_HIGH)) begin
          key_text[i*8 +: 8] <= cfg_data[(i % 8)*8 +: 8];
        end
      end
      if (cfg_index == REG_KEY_LEN) key_length    <= cfg_data[KEY_LEN_W-1:0];
      if (cfg_index == REG_DEFAULT) default_value <= cfg_data;
    end
  end

  // Advance the scanner per accepted character; return to line start after
  // the last one.
  always_ff @(posedge clk) begin
    if (rst || push) begin
      key_position <= '0;
      scan_phase   <= PH_MATCH;
      number_stage <= NS_FIRST;
      radix_select <= RX_DEC;
      accumulator  <= '0;
      word_alive   <= 3'b111;
      value_count  <= 3'd0;
    end else if (accept) begin
      key_position <= key_position_next;
      scan_phase   <= scan_phase_next;
      number_stage <= number_stage_next;
      radix_select <= radix_select_next;
      accumulator  <= accumulator_next;
      word_alive   <= word_alive_next;
      value_count  <= value_count_next;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= {result_value, found};
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
        out_data  <= {result_value, found};
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= {result_value, found};
      end
    end
  end

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data[DATA_W:1];
  assign m_tuser  = out_data[0];

endmodule

`default_nettype wire

@@ rtl/cknl_checker.sv @@
// Port-level checks for the command line key lookup block, bound to the top.
// Depends on cknl_pkg.
`default_nettype none

module cknl_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic                             s_tlast,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [cknl_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                             m_tuser
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A new result only follows the last character of a line
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("result without line end");

  // Input stalls only while a result is pending
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // A middle character makes no result
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
    else $error("result from a non-final character");

endmodule

bind cmdline_key_number_lookup cknl_checker u_cknl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
